// ----- src/pbq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pbq_pkg;

  localparam int IDX_W = 8;   // palette index width
  localparam int CH_W  = 8;   // one color channel
  localparam int BRI_W = 18;  // r^2 + g^2 + b^2 tops out at 195075
  localparam int LANES = 4;   // one lane per pixel of the 2x2 block

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [IDX_W-1:0] addr;
    rgb_t             color;
  } pal_wr_t;

  typedef struct packed {
    logic advance;  // pipeline moves this cycle
    logic wr_en;    // palette write transfer accepted
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- src/pbq_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbq_lane #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                        clk,
  input  pbq_pkg::lane_ctrl_t         ctrl,
  input  pbq_pkg::pal_wr_t            wr,
  input  logic [pbq_pkg::IDX_W-1:0]   rd_idx,
  output logic [pbq_pkg::BRI_W-1:0]   bright
);
  import pbq_pkg::*;

  localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W:0] LIMIT = (IDX_W + 1)'(PALETTE_ENTRIES);

  rgb_t             mem [PALETTE_ENTRIES];
  rgb_t             rgb_r;
  logic             hit_r;
  logic [BRI_W-1:0] bright_r;
  logic [15:0]      rr, gg, bb;

  // local palette copy; every lane sees every write
  always_ff @(posedge clk) begin
    if (ctrl.wr_en && ({1'b0, wr.addr} < LIMIT)) begin
      mem[wr.addr[AW-1:0]] <= wr.color;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      rgb_r <= mem[rd_idx[AW-1:0]];
      hit_r <= ({1'b0, rd_idx} < LIMIT);
    end
  end

  assign rr = 16'(rgb_r.red)   * 16'(rgb_r.red);
  assign gg = 16'(rgb_r.green) * 16'(rgb_r.green);
  assign bb = 16'(rgb_r.blue)  * 16'(rgb_r.blue);

  // out-of-range index counts as black
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      bright_r <= hit_r ? (BRI_W'(rr) + BRI_W'(gg) + BRI_W'(bb)) : '0;
    end
  end

  assign bright = bright_r;

endmodule

`default_nettype wire

// ----- src/pbq_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbq_merge (
  input  logic [pbq_pkg::LANES-1:0][pbq_pkg::BRI_W-1:0] bright,
  input  logic [pbq_pkg::LANES-1:0][pbq_pkg::IDX_W-1:0] idx,
  output logic [pbq_pkg::IDX_W-1:0]                     chosen
);
  import pbq_pkg::*;

  logic [BRI_W-1:0] lo_bri, hi_bri;
  logic [IDX_W-1:0] lo_idx, hi_idx;

  // strict greater-than keeps the earlier pixel on ties at every level
  always_comb begin
    if (bright[1] > bright[0]) begin
      lo_bri = bright[1];
      lo_idx = idx[1];
    end else begin
      lo_bri = bright[0];
      lo_idx = idx[0];
    end
    if (bright[3] > bright[2]) begin
      hi_bri = bright[3];
      hi_idx = idx[3];
    end else begin
      hi_bri = bright[2];
      hi_idx = idx[2];
    end
    chosen = (hi_bri > lo_bri) ? hi_idx : lo_idx;
  end

endmodule

`default_nettype wire

// ----- src/palette_brightest_of_quad_select_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Brightest-of-2x2 selector for palette-indexed image halving.
//
// Input channel (in_valid / in_stall): one transfer per item. Opcode write
// stores entry_red/green/blue at entry_number (ignored past the palette) and
// gives no result. Opcode select looks up the four indices of a 2x2 block
// and returns the index with the largest r^2+g^2+b^2; ties go to top-left,
// then top-right, bottom-left, bottom-right.
// Result channel (out_valid / out_stall): one transfer per select item.
//
// A select passes the palette read, then squares and sum, then the merge
// into the output register. Throughput: one item per cycle unless stalled.
// Four lanes each keep a palette copy with a single read port, so all four
// lookups happen in the same cycle.
// Stall: the whole pipeline freezes while a result waits and out_stall is
// high; in_stall then goes high in the same cycle. A select read never sees
// a stale entry, since writes land at acceptance ahead of any later read.
// Reset: clears the pipeline valid bits only. Palette contents are
// undefined until written; nothing is cleared.
module palette_brightest_of_quad_select_unit #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_opcode,
  input  logic [pbq_pkg::IDX_W-1:0] in_entry_number,
  input  logic [pbq_pkg::CH_W-1:0]  in_entry_red,
  input  logic [pbq_pkg::CH_W-1:0]  in_entry_green,
  input  logic [pbq_pkg::CH_W-1:0]  in_entry_blue,
  input  logic [pbq_pkg::IDX_W-1:0] in_top_left,
  input  logic [pbq_pkg::IDX_W-1:0] in_top_right,
  input  logic [pbq_pkg::IDX_W-1:0] in_bottom_left,
  input  logic [pbq_pkg::IDX_W-1:0] in_bottom_right,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [pbq_pkg::IDX_W-1:0] out_chosen_index
);
  import pbq_pkg::*;

  logic                              advance;
  lane_ctrl_t                        ctrl;
  pal_wr_t                           wr;
  logic [LANES-1:0][IDX_W-1:0]       quad;
  logic [LANES-1:0][IDX_W-1:0]       quad1_r, quad2_r;
  logic [LANES-1:0][BRI_W-1:0]       bright;
  logic                              s1_vld_r, s2_vld_r, out_vld_r;
  logic [IDX_W-1:0]                  chosen;
  logic [IDX_W-1:0]                  out_idx_r;

  // pipeline moves unless a finished result is held by the receiver
  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = !advance;

  assign ctrl.advance = advance;
  assign ctrl.wr_en   = advance && in_valid && (in_opcode == OP_WRITE);

  assign wr.addr        = in_entry_number;
  assign wr.color.red   = in_entry_red;
  assign wr.color.green = in_entry_green;
  assign wr.color.blue  = in_entry_blue;

  // lane order sets tie priority
  assign quad[0] = in_top_left;
  assign quad[1] = in_top_right;
  assign quad[2] = in_bottom_left;
  assign quad[3] = in_bottom_right;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    pbq_lane #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .wr     (wr),
      .rd_idx (quad[i]),
      .bright (bright[i])
    );
  end

  // index tags travel alongside the lane pipelines
  always_ff @(posedge clk) begin
    if (advance) begin
      quad1_r <= quad;
      quad2_r <= quad1_r;
    end
  end

  pbq_merge u_merge (
    .bright (bright),
    .idx    (quad2_r),
    .chosen (chosen)
  );

  // only select transfers produce a result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (advance) begin
      s1_vld_r  <= in_valid && (in_opcode == OP_SELECT);
      s2_vld_r  <= s1_vld_r;
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_idx_r <= chosen;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_chosen_index = out_idx_r;

endmodule

`default_nettype wire

// ----- src/pbq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pbq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [pbq_pkg::IDX_W-1:0] out_chosen_index
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_chosen_index)))
    else $error("result changed while stalled");

  // input back-pressure only ever comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // reset empties the pipeline
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind palette_brightest_of_quad_select_unit pbq_checker u_pbq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_chosen_index (out_chosen_index)
);

`default_nettype wire
